/* rtl/core/csvd_pkg.sv */
// ----------------------------------------------------------------------------
// csvd_pkg: shared types and constants for the compact signed varint decoder
// Word layouts on both channels, decoder state and status codes.
// ----------------------------------------------------------------------------
package csvd_pkg;

    // Status codes carried in the result word
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TOO_LONG  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW  = 2'd2;
    localparam logic [1:0] ST_TRUNCATED = 2'd3;

    // Longest encoding in bytes, and the largest payload the last byte may hold
    localparam logic [2:0] LONGEST_CODE = 3'd5;
    localparam logic [6:0] LAST_PAY_MAX = 7'h0f;

    localparam int MAG_W = 31;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_end;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] decoded_value;
        logic [2:0]         byte_count;
        logic [1:0]         status;
    } out_word_t;

    // Decoder state carried from byte to byte
    typedef struct packed {
        logic             open_val;
        logic             sign;
        logic [2:0]       count;
        logic [MAG_W-1:0] mag;
    } dec_state_t;

endpackage

/* rtl/core/compact_signed_varint_decoder.sv */
// ----------------------------------------------------------------------------
// compact_signed_varint_decoder: sign-magnitude compact index decoder
// Path: a word is taken into the input register, decoded there by the step and
//   its result (if any) is loaded into and presented from the result register.
// Throughput: one byte per cycle, set by the single decode step between the
//   input register and the result register; stalls only on result backpressure.
// Reset (rst_n low, asynchronous): both registers empty, decoder awaits a first byte.
// ----------------------------------------------------------------------------
module compact_signed_varint_decoder (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  csvd_pkg::in_word_t  item,
    output logic                result_valid,
    input  logic                result_ready,
    output csvd_pkg::out_word_t result
);

    // input register
    logic                 in_valid_reg;
    csvd_pkg::in_word_t   in_word_reg;

    // decoder state across the bytes of one value
    csvd_pkg::dec_state_t state_reg;
    csvd_pkg::dec_state_t state_next;

    // result register
    logic                 out_valid_reg;
    csvd_pkg::out_word_t  out_word_reg;

    logic                 step_res_valid;
    csvd_pkg::out_word_t  step_res;
    logic                 out_free;
    logic                 advance;

    csvd_step u_step (
        .state      (state_reg),
        .word       (in_word_reg),
        .state_next (state_next),
        .res_valid  (step_res_valid),
        .res        (step_res)
    );

    // The result slot frees when empty or when its word leaves this cycle.
    assign out_free = !out_valid_reg || result_ready;

    // Advance the held byte unless it makes a result and the slot is blocked.
    // A byte that only extends the value never waits on the output side.
    assign advance = in_valid_reg && (!step_res_valid || out_free);

    // Take a new byte whenever the input register empties this cycle.
    assign item_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_ready)
                in_valid_reg <= item_valid;
            if (advance)
                state_reg <= state_next;
            // load a fresh result, or drop the taken one
            if (advance && step_res_valid)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
            in_word_reg <= item;
        if (advance && step_res_valid)
            out_word_reg <= step_res;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_word_reg;

endmodule

/* rtl/core/csvd_step.sv */
// ----------------------------------------------------------------------------
// csvd_step: one-byte decode step
// Combines the current decoder state with one input byte and gives the next
// state and, when the value ends or fails, one result word.
// ----------------------------------------------------------------------------
module csvd_step (
    input  csvd_pkg::dec_state_t state,
    input  csvd_pkg::in_word_t   word,
    output csvd_pkg::dec_state_t state_next,
    output logic                 res_valid,
    output csvd_pkg::out_word_t  res
);

    logic [6:0]                 payload;
    logic                       more;
    logic                       sign_n;
    logic [2:0]                 count_n;
    logic [csvd_pkg::MAG_W-1:0] mag_n;
    logic [csvd_pkg::MAG_W-1:0] shifted;
    logic                       fail_ovf;
    logic                       fail_long;
    logic [31:0]                mag_ext;

    assign payload = word.data_byte[6:0];

    always_comb
    begin
        // place the payload at its group position; out-of-range counts use the last group
        unique case (state.count)
            3'd1:    shifted = {18'b0, payload, 6'b0};
            3'd2:    shifted = {11'b0, payload, 13'b0};
            3'd3:    shifted = {4'b0, payload, 20'b0};
            default: shifted = {payload[3:0], 27'b0};
        endcase
    end

    always_comb
    begin
        fail_ovf  = 1'b0;
        fail_long = 1'b0;
        if (!state.open_val)
        begin
            sign_n  = word.data_byte[7];
            mag_n   = {25'b0, word.data_byte[5:0]};
            count_n = 3'd1;
            more    = word.data_byte[6];
        end
        else
        begin
            sign_n  = state.sign;
            mag_n   = state.mag | shifted;
            more    = word.data_byte[7];
            unique case (state.count)
                3'd1:    count_n = 3'd2;
                3'd2:    count_n = 3'd3;
                3'd3:    count_n = 3'd4;
                default: count_n = csvd_pkg::LONGEST_CODE;
            endcase
            if (count_n == csvd_pkg::LONGEST_CODE)
            begin
                fail_ovf  = payload > csvd_pkg::LAST_PAY_MAX;
                fail_long = more;
            end
        end
    end

    assign mag_ext = {1'b0, mag_n};

    always_comb
    begin
        res.decoded_value = '0;
        res.byte_count    = count_n;
        res.status        = csvd_pkg::ST_OK;
        res_valid         = 1'b1;
        priority if (fail_ovf)
            res.status = csvd_pkg::ST_OVERFLOW;
        else if (fail_long)
            res.status = csvd_pkg::ST_TOO_LONG;
        else if (!more)
            res.decoded_value = sign_n ? $signed(32'd0 - mag_ext) : $signed(mag_ext);
        else if (word.buffer_end)
            res.status = csvd_pkg::ST_TRUNCATED;
        else
            res_valid = 1'b0;
    end

    always_comb
    begin
        // any result starts the decoder afresh
        if (res_valid)
        begin
            state_next = '0;
        end
        else
        begin
            state_next.open_val = 1'b1;
            state_next.sign     = sign_n;
            state_next.count    = count_n;
            state_next.mag      = mag_n;
        end
    end

endmodule
